@@ sv/opr_pkg.sv @@
// opr_pkg: shared types and constants for the optimal page replacement block
// transfer payload structs, controller/datapath command and status structs
// no dependencies

package opr_pkg;

    localparam int PAGE_BITS      = 12;
    localparam int SLOT_W         = 3;
    localparam int FAULT_W        = 7;
    localparam int FC_CFG_W       = 4;
    localparam int DEF_MAX_REFS   = 64;
    localparam int DEF_MAX_FRAMES = 8;

    localparam logic [FC_CFG_W-1:0] FRAME_COUNT_RST = 4'd3;

    typedef struct packed {
        logic [PAGE_BITS-1:0] ref_page;
        logic                 ref_last;
    } item_t;

    typedef struct packed {
        logic [PAGE_BITS-1:0] out_page;
        logic                 hit;
        logic [SLOT_W-1:0]    slot_written;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [FAULT_W-1:0]   fault_total;
        logic                 truncated;
        logic                 run_last;
    } result_t;

    typedef struct packed {
        logic accept;
        logic begin_run;
        logic read_cur;
        logic look;
        logic scan;
        logic pick;
        logic evict;
    } cmd_t;

    typedef struct packed {
        logic resolved;
        logic scan_done;
        logic pick_done;
        logic is_last;
    } status_t;

endpackage

@@ sv/opr_ctrl.sv @@
// opr_ctrl: sequencing state machine for loading and replaying the reference string
// depends on opr_pkg (cmd_t, status_t)

module opr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             ref_last,
    input  opr_pkg::status_t status,
    output opr_pkg::cmd_t    cmd,
    output logic             busy
);
    import opr_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_EVICT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (ref_last)
                    begin
                        cmd.begin_run = 1'b1;
                        state_next    = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_cur = 1'b1;
                state_next   = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
                if (status.resolved)
                begin
                    state_next = status.is_last ? S_LOAD : S_READ;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick = 1'b1;
                if (status.pick_done)
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = status.is_last ? S_LOAD : S_READ;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign busy = (state_reg != S_LOAD);

endmodule

@@ sv/opr_dp.sv @@
// opr_dp: reference memory, frame lanes, next-use scan lanes, counters and result register
// depends on opr_pkg (item_t, result_t, cmd_t, status_t, constants)

module opr_dp #(
    parameter int MAX_REFS   = opr_pkg::DEF_MAX_REFS,
    parameter int MAX_FRAMES = opr_pkg::DEF_MAX_FRAMES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  opr_pkg::cmd_t                   cmd,
    input  opr_pkg::item_t                  item,
    input  logic                            cfg_we,
    input  logic [opr_pkg::FC_CFG_W-1:0]    cfg_data,
    output opr_pkg::status_t                status,
    output logic                            result_strobe,
    output opr_pkg::result_t                result
);
    import opr_pkg::*;

    localparam int CNT_W = $clog2(MAX_REFS + 1);
    localparam int IDX_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int FC_W  = $clog2(MAX_FRAMES + 1);
    localparam int FI_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [PAGE_BITS-1:0] mem [MAX_REFS];
    logic [PAGE_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;

    logic [CNT_W-1:0]     count_reg;
    logic                 overflow_reg;
    logic [FC_CFG_W-1:0]  frame_count_reg;
    logic [FC_W-1:0]      nf_reg;
    logic [FC_W-1:0]      nf_calc;
    logic [FC_W-1:0]      filled_reg;
    logic [FAULT_W-1:0]   fault_reg;
    logic [IDX_W-1:0]     k_reg;

    logic [PAGE_BITS-1:0] frame_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [MAX_FRAMES-1:0] found_reg;
    logic [IDX_W-1:0]     dist_reg [MAX_FRAMES];

    logic [CNT_W-1:0]     scan_addr_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     data_idx_reg;
    logic [FI_W-1:0]      pick_idx_reg;
    logic [FI_W-1:0]      best_reg;
    logic [IDX_W-1:0]     best_dist_reg;
    logic [PAGE_BITS-1:0] cur_page_reg;

    logic                 strobe_reg;
    result_t              result_reg;

    logic [MAX_FRAMES-1:0] hit_vec;
    logic [MAX_FRAMES-1:0] match_vec;
    logic                 hit;
    logic                 free_slot;
    logic                 is_last;
    logic                 scan_issue;
    logic                 emit;
    logic [FI_W-1:0]      fill_idx;
    logic                 pick_found;
    logic [IDX_W-1:0]     pick_dist;
    logic                 pick_better;

    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            nf_calc = FC_W'(1);
        end
        else if (int'(frame_count_reg) > MAX_FRAMES)
        begin
            nf_calc = FC_W'(MAX_FRAMES);
        end
        else
        begin
            nf_calc = FC_W'(frame_count_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            match_vec[i] = (frame_reg[i] == rd_data_reg);
            hit_vec[i]   = valid_reg[i] && (FC_W'(i) < nf_reg) && match_vec[i];
        end
    end

    assign hit         = |hit_vec;
    assign free_slot   = (filled_reg < nf_reg);
    assign is_last     = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign scan_issue  = cmd.scan && (scan_addr_reg < count_reg);
    assign emit        = (cmd.look && (hit || free_slot)) || cmd.evict;
    assign fill_idx    = FI_W'(filled_reg);
    assign pick_found  = found_reg[pick_idx_reg];
    assign pick_dist   = dist_reg[pick_idx_reg];
    assign pick_better = (pick_idx_reg == '0) || (pick_dist > best_dist_reg);

    assign rd_en   = cmd.read_cur || scan_issue;
    assign rd_addr = cmd.read_cur ? k_reg : scan_addr_reg[IDX_W-1:0];

    assign status.resolved  = hit || free_slot;
    assign status.scan_done = !scan_issue && !pend_reg;
    assign status.pick_done = !pick_found
                              || ((FC_W'(pick_idx_reg) + FC_W'(1)) == nf_reg);
    assign status.is_last   = is_last;

    // reference memory
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (count_reg < CNT_W'(MAX_REFS)))
        begin
            mem[count_reg[IDX_W-1:0]] <= item.ref_page;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            overflow_reg    <= 1'b0;
            frame_count_reg <= FRAME_COUNT_RST;
            nf_reg          <= FC_W'(1);
            filled_reg      <= '0;
            fault_reg       <= '0;
            k_reg           <= '0;
            valid_reg       <= '0;
            found_reg       <= '0;
            pend_reg        <= 1'b0;
            scan_addr_reg   <= '0;
            pick_idx_reg    <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit;
            if (cfg_we)
            begin
                frame_count_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                if (count_reg < CNT_W'(MAX_REFS))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.begin_run)
            begin
                nf_reg     <= nf_calc;
                valid_reg  <= '0;
                filled_reg <= '0;
                fault_reg  <= '0;
                k_reg      <= '0;
            end
            if (cmd.look && !hit && free_slot)
            begin
                valid_reg[fill_idx] <= 1'b1;
                filled_reg          <= filled_reg + FC_W'(1);
                fault_reg           <= fault_reg + FAULT_W'(1);
            end
            if (cmd.look && !hit && !free_slot)
            begin
                scan_addr_reg <= CNT_W'(k_reg) + CNT_W'(1);
                pend_reg      <= 1'b0;
                found_reg     <= '0;
                pick_idx_reg  <= '0;
            end
            if (cmd.scan)
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_addr_reg <= scan_addr_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    found_reg <= found_reg | match_vec;
                end
            end
            if (cmd.pick)
            begin
                pick_idx_reg <= pick_idx_reg + FI_W'(1);
            end
            if (cmd.evict)
            begin
                valid_reg[best_reg] <= 1'b1;
                fault_reg           <= fault_reg + FAULT_W'(1);
            end
            if (emit)
            begin
                if (is_last)
                begin
                    count_reg    <= '0;
                    overflow_reg <= 1'b0;
                    k_reg        <= '0;
                end
                else
                begin
                    k_reg <= k_reg + IDX_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.look)
        begin
            cur_page_reg <= rd_data_reg;
        end
        if (cmd.look && !hit && free_slot)
        begin
            frame_reg[fill_idx] <= rd_data_reg;
        end
        if (cmd.scan && pend_reg)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                if (!found_reg[i] && match_vec[i])
                begin
                    dist_reg[i] <= data_idx_reg;
                end
            end
        end
        if (scan_issue)
        begin
            data_idx_reg <= scan_addr_reg[IDX_W-1:0];
        end
        if (cmd.pick && (!pick_found || pick_better))
        begin
            best_reg      <= pick_idx_reg;
            best_dist_reg <= pick_dist;
        end
        if (cmd.evict)
        begin
            frame_reg[best_reg] <= cur_page_reg;
        end
        if (emit)
        begin
            result_reg.truncated   <= overflow_reg;
            result_reg.run_last    <= is_last;
            if (cmd.evict)
            begin
                result_reg.out_page      <= cur_page_reg;
                result_reg.hit           <= 1'b0;
                result_reg.slot_written  <= SLOT_W'(best_reg);
                result_reg.evicted_valid <= 1'b1;
                result_reg.evicted_page  <= frame_reg[best_reg];
                result_reg.fault_total   <= fault_reg + FAULT_W'(1);
            end
            else
            begin
                result_reg.out_page      <= rd_data_reg;
                result_reg.hit           <= hit;
                result_reg.slot_written  <= hit ? '0 : SLOT_W'(fill_idx);
                result_reg.evicted_valid <= 1'b0;
                result_reg.evicted_page  <= '0;
                result_reg.fault_total   <= hit ? fault_reg : fault_reg + FAULT_W'(1);
            end
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

@@ sv/optimal_page_replacement_top.sv @@
// optimal_page_replacement_top: top level of the optimal (farthest next use) page replacement block
// depends on opr_pkg, opr_ctrl, opr_dp
//
// usage
//   item transfer: start with busy low takes one reference (ref_page, ref_last)
//   a reference without ref_last is stored and gives no result
//   references beyond MAX_REFS are dropped and every result of that run shows truncated
//   ref_last starts the run: busy goes high and one result per stored reference follows
//   result transfer: result_strobe marks result for exactly one cycle, it cannot be held off
//   cfg_we/cfg_data write frame_count at any edge; it is sampled when the run starts
// steps per reference of a run
//   hit or fill of a free frame: memory read, then frame compare
//   replacement: memory read and frame compare, then the single read port of the
//   reference memory scans future references one per cycle, then a walk over
//   the frame lanes picks the victim, which is then evicted
//   the result is registered and appears in the cycle after its decision; busy drops with the last result
// reset
//   rst_n clears counts, valid bits and the run; frame_count returns to 3

module optimal_page_replacement_top #(
    parameter int MAX_REFS   = opr_pkg::DEF_MAX_REFS,
    parameter int MAX_FRAMES = opr_pkg::DEF_MAX_FRAMES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  opr_pkg::item_t               item,
    input  logic                         cfg_we,
    input  logic [opr_pkg::FC_CFG_W-1:0] cfg_data,
    output logic                         result_strobe,
    output opr_pkg::result_t             result
);
    import opr_pkg::*;

    cmd_t    cmd;
    status_t status;

    opr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .ref_last (item.ref_last),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    opr_dp #(
        .MAX_REFS   (MAX_REFS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item          (item),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .status        (status),
        .result_strobe (result_strobe),
        .result        (result)
    );

    a_strobe_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result without a run in progress");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.run_last) |-> !busy)
        else $error("still busy after the final result");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.ref_last) |=> !busy)
        else $error("loading a reference started a run");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.hit) |-> (!result.evicted_valid && result.slot_written == '0))
        else $error("hit result reports a frame write");

endmodule
